[src/wls_pkg.sv]
// word length statistics: shared constants, types and helper functions
package wls_pkg;

   // sentence limits and field widths
   localparam int MAX_CHARS  = 1024;
   localparam int LEN_W      = $clog2(MAX_CHARS + 1);
   localparam int TALLY_W    = 10;
   localparam int SQ_W       = $clog2(MAX_CHARS * MAX_CHARS + 1);
   localparam int FRAC_BITS  = 8;
   localparam int Q_W        = LEN_W + FRAC_BITS;
   localparam int CHAR_W     = 8;

   // iterative engine widths
   localparam int DIFF_W     = TALLY_W + SQ_W;
   localparam int SQRT_FRAC  = 2 * FRAC_BITS;
   localparam int RAD_W      = ((DIFF_W + SQRT_FRAC + 1) / 2) * 2;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int CNT_W      = $clog2(ROOT_W);

   // step counts of each pass through the shared adder
   localparam int MEAN_STEPS = Q_W;
   localparam int NS_STEPS   = TALLY_W;
   localparam int TT_STEPS   = LEN_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DEV_STEPS  = ROOT_W;

   // saturation limits
   localparam logic [TALLY_W-1:0] TALLY_CAP = {TALLY_W{1'b1}};

   // delimiter and line feed codes
   localparam logic [CHAR_W-1:0] CHAR_PERIOD    = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COMMA     = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [CHAR_W-1:0] CHAR_COLON     = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [CHAR_W-1:0] CHAR_EXCLAIM   = 8'h21;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LF        = 8'h0A;

   // engine sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_MUL_NS,
      ST_MUL_TT,
      ST_SUB,
      ST_SQRT,
      ST_DIV_DEV,
      ST_DONE
   } wls_state_type;

   // sentence totals handed to the engine
   typedef struct packed {
      logic [TALLY_W-1:0] n;
      logic [LEN_W-1:0]   t;
      logic [SQ_W-1:0]    s;
   } wls_stats_type;

   // engine control from the top level
   typedef struct packed {
      logic start;
      logic take;
   } wls_ctrl_type;

   // engine status to the top level
   typedef struct packed {
      logic idle;
      logic done;
   } wls_status_type;

   // engine results
   typedef struct packed {
      logic [Q_W-1:0] mean;
      logic [Q_W-1:0] dev;
   } wls_result_type;

   // clamp a root quotient to the width of a result field
   function automatic logic [Q_W-1:0] sat_q(input logic [ROOT_W-1:0] value);
      logic [Q_W-1:0] res;
      if (value[ROOT_W-1:Q_W] != '0) begin
         res = {Q_W{1'b1}};
      end else begin
         res = value[Q_W-1:0];
      end
      return res;
   endfunction

endpackage

[src/word_length_statistics.sv]
// word length statistics: top level with character scan, totals and result register
//
// Takes a sentence one character per transfer on the req_ channel. Delimiters
// (. , ; : ? ! and space) end a word, every other byte lengthens it; the
// character with req_is_last set also ends the word and counts as a letter
// unless it is a delimiter or a line feed. That transfer produces one rsp_
// transfer with shortest, longest, letter total, word count, and mean and
// population standard deviation of the lengths in unsigned Q.8.
// Ordinary characters are taken one per cycle. After the final character
// req_stall stays high while the engine works and until its result is taken
// into the output register; rsp_valid rises in the cycle req_stall falls. The
// engine time is set by the shared adder, which runs the mean division, two
// multiplies, a 24-step square root and a 24-step division one bit or digit
// per cycle.
// The result waits in an output register while rsp_stall is high; the next
// sentence streams in meanwhile and only its final step waits for the slot.
// Reset is synchronous: all totals clear, no response is pending.
module word_length_statistics (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wls_pkg::CHAR_W-1:0]    req_char_code,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wls_pkg::LEN_W-1:0]     rsp_shortest,
   output logic [wls_pkg::LEN_W-1:0]     rsp_longest,
   output logic [wls_pkg::LEN_W-1:0]     rsp_letter_sum,
   output logic [wls_pkg::TALLY_W-1:0]   rsp_words,
   output logic [wls_pkg::Q_W-1:0]       rsp_mean_q8,
   output logic [wls_pkg::Q_W-1:0]       rsp_deviation_q8
);
   import wls_pkg::*;

   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_CHARS);
   localparam logic [SQ_W-1:0]  SQ_CAP  = SQ_W'(MAX_CHARS * MAX_CHARS);

   logic [LEN_W-1:0]   cur_len_ff, cur_len_in;
   logic [SQ_W-1:0]    cur_sq_ff, cur_sq_in;
   logic [TALLY_W-1:0] word_tally_ff, word_tally_in;
   logic [LEN_W-1:0]   len_total_ff, len_total_in;
   logic [SQ_W-1:0]    square_total_ff, square_total_in;
   logic [LEN_W-1:0]   min_seen_ff, min_seen_in;
   logic [LEN_W-1:0]   max_seen_ff, max_seen_in;
   logic               start_ff, start_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [LEN_W-1:0]   rsp_shortest_ff, rsp_longest_ff, rsp_letter_sum_ff;
   logic [TALLY_W-1:0] rsp_words_ff;
   logic [Q_W-1:0]     rsp_mean_ff, rsp_dev_ff;

   logic               req_xfer;
   logic               is_delim;
   logic               counts_letter;
   logic               len_inc;
   logic               ends_word;
   logic               closes;
   logic               no_words;
   logic [LEN_W-1:0]   new_len;
   logic [SQ_W-1:0]    new_sq;
   logic [LEN_W:0]     total_sum;
   logic [SQ_W:0]      sq_sum;

   wls_ctrl_type       eng_ctrl;
   wls_status_type     eng_status;
   wls_result_type     eng_result;
   wls_stats_type      eng_stats;

   // handshake
   assign req_stall = !eng_status.idle || start_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign eng_ctrl.start = start_ff;
   assign eng_ctrl.take  = eng_status.done && (!rsp_valid_ff || !rsp_stall);

   // character decode
   always_comb begin
      is_delim = (req_char_code == CHAR_PERIOD)    || (req_char_code == CHAR_COMMA)
              || (req_char_code == CHAR_SEMICOLON) || (req_char_code == CHAR_COLON)
              || (req_char_code == CHAR_QUESTION)  || (req_char_code == CHAR_EXCLAIM)
              || (req_char_code == CHAR_SPACE);
      counts_letter = !is_delim && !(req_is_last && (req_char_code == CHAR_LF));
      len_inc   = counts_letter && (cur_len_ff < LEN_CAP);
      ends_word = is_delim || req_is_last;
   end

   // running length and its square, kept by adding 2*len+1 on each letter
   always_comb begin
      new_len = cur_len_ff + LEN_W'(len_inc);
      new_sq  = cur_sq_ff + (len_inc ? {{(SQ_W-LEN_W-1){1'b0}}, cur_len_ff, 1'b1} : '0);
      closes  = ends_word && (new_len != '0);
      total_sum = {1'b0, len_total_ff} + {1'b0, new_len};
      sq_sum    = {1'b0, square_total_ff} + {1'b0, new_sq};
   end

   // sentence totals
   always_comb begin
      cur_len_in      = cur_len_ff;
      cur_sq_in       = cur_sq_ff;
      word_tally_in   = word_tally_ff;
      len_total_in    = len_total_ff;
      square_total_in = square_total_ff;
      min_seen_in     = min_seen_ff;
      max_seen_in     = max_seen_ff;
      if (eng_ctrl.take) begin
         cur_len_in      = '0;
         cur_sq_in       = '0;
         word_tally_in   = '0;
         len_total_in    = '0;
         square_total_in = '0;
         min_seen_in     = '1;
         max_seen_in     = '0;
      end else if (req_xfer) begin
         cur_len_in = ends_word ? '0 : new_len;
         cur_sq_in  = ends_word ? '0 : new_sq;
         if (closes) begin
            if ((word_tally_ff == '0) || (new_len < min_seen_ff)) begin
               min_seen_in = new_len;
            end
            if (new_len > max_seen_ff) begin
               max_seen_in = new_len;
            end
            if (word_tally_ff != TALLY_CAP) begin
               word_tally_in = word_tally_ff + TALLY_W'(1);
            end
            len_total_in    = (total_sum > {1'b0, LEN_CAP}) ? LEN_CAP
                                                            : total_sum[LEN_W-1:0];
            square_total_in = (sq_sum > {1'b0, SQ_CAP}) ? SQ_CAP : sq_sum[SQ_W-1:0];
         end
      end
   end

   // engine start and response valid
   always_comb begin
      start_in     = req_xfer && req_is_last;
      rsp_valid_in = rsp_valid_ff;
      if (eng_ctrl.take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and totals registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_len_ff      <= '0;
         cur_sq_ff       <= '0;
         word_tally_ff   <= '0;
         len_total_ff    <= '0;
         square_total_ff <= '0;
         min_seen_ff     <= '1;
         max_seen_ff     <= '0;
         start_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cur_len_ff      <= cur_len_in;
         cur_sq_ff       <= cur_sq_in;
         word_tally_ff   <= word_tally_in;
         len_total_ff    <= len_total_in;
         square_total_ff <= square_total_in;
         min_seen_ff     <= min_seen_in;
         max_seen_ff     <= max_seen_in;
         start_ff        <= start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // response payload, loaded when the engine result is taken
   assign no_words = (word_tally_ff == '0);

   always_ff @(posedge clock) begin
      if (eng_ctrl.take) begin
         rsp_shortest_ff   <= no_words ? '0 : min_seen_ff;
         rsp_longest_ff    <= max_seen_ff;
         rsp_letter_sum_ff <= len_total_ff;
         rsp_words_ff      <= word_tally_ff;
         rsp_mean_ff       <= eng_result.mean;
         rsp_dev_ff        <= eng_result.dev;
      end
   end

   // mean and deviation engine
   assign eng_stats.n = word_tally_ff;
   assign eng_stats.t = len_total_ff;
   assign eng_stats.s = square_total_ff;

   wls_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (eng_ctrl),
      .stats  (eng_stats),
      .status (eng_status),
      .result (eng_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_shortest     = rsp_shortest_ff;
   assign rsp_longest      = rsp_longest_ff;
   assign rsp_letter_sum   = rsp_letter_sum_ff;
   assign rsp_words        = rsp_words_ff;
   assign rsp_mean_q8      = rsp_mean_ff;
   assign rsp_deviation_q8 = rsp_dev_ff;

`ifndef SYNTHESIS
   // totals hold while the engine is working on them
   a_totals_hold: assert property (@(posedge clock) disable iff (reset)
      (!eng_status.idle && !eng_status.done) |=>
         ($stable(word_tally_ff) && $stable(len_total_ff) && $stable(square_total_ff)))
      else $error("sentence totals changed during computation");

   // a new response only follows a finished engine run
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(eng_status.done))
      else $error("response raised without a finished computation");

   // a sentence without words reports all zeros
   a_no_words_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_words == '0)) |->
         ((rsp_shortest == '0) && (rsp_longest == '0) && (rsp_letter_sum == '0)
          && (rsp_mean_q8 == '0) && (rsp_deviation_q8 == '0)))
      else $error("empty sentence gave non-zero statistics");

   // a single word has equal extremes and no spread
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_words == TALLY_W'(1))) |->
         ((rsp_shortest == rsp_longest) && (rsp_deviation_q8 == '0)))
      else $error("single word statistics inconsistent");
`endif

endmodule

[src/wls_engine.sv]
// word length statistics: end of sentence mean and deviation engine on one shared adder
module wls_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  wls_pkg::wls_ctrl_type   ctrl,
   input  wls_pkg::wls_stats_type  stats,
   output wls_pkg::wls_status_type status,
   output wls_pkg::wls_result_type result
);
   import wls_pkg::*;

   wls_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RAD_W-1:0]   acc_ff, acc_in;
   logic [RAD_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [Q_W-1:0]     mean_ff, mean_in;

   // shared adder and subtractor
   logic [RAD_W-1:0]   op_a, op_b;
   logic               op_sub;
   logic [RAD_W:0]     sum;
   logic               no_borrow;
   logic               sub_pos;
   logic               last_step;
   logic [ROOT_W-1:0]  root_step;
   logic [RAD_W-1:0]   div_shift;
   logic [RAD_W-1:0]   sqrt_shift;
   logic [RAD_W-1:0]   mcand;

   assign sum       = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)}
                      + {{RAD_W{1'b0}}, op_sub};
   assign no_borrow = sum[RAD_W];
   assign sub_pos   = no_borrow && (sum[RAD_W-1:0] != '0);
   assign last_step = (cnt_ff == '0);
   assign root_step = {root_ff[ROOT_W-2:0], no_borrow};

   // partial remainders shifted for the next digit
   assign div_shift  = {rem_ff[RAD_W-2:0], root_ff[ROOT_W-1]};
   assign sqrt_shift = {rem_ff[RAD_W-3:0], acc_ff[RAD_W-1 -: 2]};
   assign mcand      = (state_ff == ST_MUL_NS) ? {{(RAD_W-SQ_W){1'b0}}, stats.s}
                                              : {{(RAD_W-LEN_W){1'b0}}, stats.t};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               state_in = (stats.n == '0) ? ST_DONE : ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (last_step) state_in = ST_MUL_NS;
         end
         ST_MUL_NS: begin
            if (last_step) state_in = ST_MUL_TT;
         end
         ST_MUL_TT: begin
            if (last_step) state_in = ST_SUB;
         end
         ST_SUB: begin
            state_in = sub_pos ? ST_SQRT : ST_DONE;
         end
         ST_SQRT: begin
            if (last_step) state_in = ST_DIV_DEV;
         end
         ST_DIV_DEV: begin
            if (last_step) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctrl.take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // operand selection and datapath updates
   always_comb begin
      op_a    = '0;
      op_b    = '0;
      op_sub  = 1'b0;
      cnt_in  = cnt_ff - CNT_W'(1);
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      mean_in = mean_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = cnt_ff;
            if (ctrl.start) begin
               rem_in  = '0;
               cnt_in  = CNT_W'(MEAN_STEPS - 1);
               mean_in = '0;
               if (stats.n == '0) begin
                  root_in = '0;
               end else begin
                  root_in = {stats.t, {(ROOT_W-LEN_W){1'b0}}};
               end
            end
         end
         ST_DIV_MEAN, ST_DIV_DEV: begin
            // restoring division by the word count, one quotient bit a step
            op_a    = div_shift;
            op_b    = {{(RAD_W-TALLY_W){1'b0}}, stats.n};
            op_sub  = 1'b1;
            rem_in  = no_borrow ? sum[RAD_W-1:0] : div_shift;
            root_in = root_step;
            if (last_step && (state_ff == ST_DIV_MEAN)) begin
               mean_in = root_step[Q_W-1:0];
               acc_in  = '0;
               root_in = {stats.n, {(ROOT_W-TALLY_W){1'b0}}};
               cnt_in  = CNT_W'(NS_STEPS - 1);
            end
         end
         ST_MUL_NS, ST_MUL_TT: begin
            // shift and add multiply, multiplier bits from the top of root
            op_a    = {acc_ff[RAD_W-2:0], 1'b0};
            op_b    = root_ff[ROOT_W-1] ? mcand : '0;
            acc_in  = sum[RAD_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
            if (last_step && (state_ff == ST_MUL_NS)) begin
               rem_in  = sum[RAD_W-1:0];
               acc_in  = '0;
               root_in = {stats.t, {(ROOT_W-LEN_W){1'b0}}};
               cnt_in  = CNT_W'(TT_STEPS - 1);
            end
         end
         ST_SUB: begin
            // n*S minus T*T, scaled by two fraction bytes so the root has one fraction byte
            op_a    = rem_ff;
            op_b    = acc_ff;
            op_sub  = 1'b1;
            rem_in  = '0;
            root_in = '0;
            acc_in  = {sum[RAD_W-1-SQRT_FRAC:0], {SQRT_FRAC{1'b0}}};
            cnt_in  = CNT_W'(SQRT_STEPS - 1);
         end
         ST_SQRT: begin
            // digit by digit square root, two radicand bits a step
            op_a    = sqrt_shift;
            op_b    = {{(RAD_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
            op_sub  = 1'b1;
            rem_in  = no_borrow ? sum[RAD_W-1:0] : sqrt_shift;
            root_in = root_step;
            acc_in  = {acc_ff[RAD_W-3:0], 2'b00};
            if (last_step) begin
               rem_in = '0;
               cnt_in = CNT_W'(DEV_STEPS - 1);
            end
         end
         ST_DONE: begin
            cnt_in = cnt_ff;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      mean_ff <= mean_in;
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);
   assign result.mean = mean_ff;
   assign result.dev  = sat_q(root_ff);

endmodule
